/* rtl/ostb_pkg.sv */
// ----------------------------------------------------------------------------
// One-shot timer bank package
// Shared constants, command codes and sequencer states of the timer bank.
// ----------------------------------------------------------------------------
package ostb_pkg;

	// Bank size and tick period in milliseconds.
	localparam int NUM_TIMERS   = 8;
	localparam int TICK_DIVISOR = 10;

	// Field widths fixed by the interface.
	localparam int CMD_W   = 2;
	localparam int INDEX_W = 3;
	localparam int MS_W    = 32;
	localparam int MASK_W  = 8;

	// Width of one stored count; larger quotients saturate.
	localparam int COUNT_W = 29;

	// Index width for walking the bank.
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// Reciprocal of the tick period, rounded up. With a shift of MS_W plus
	// the divisor's bit length, the product gives the exact floor quotient
	// for every dividend of MS_W bits.
	localparam int RECIP_L     = $clog2(TICK_DIVISOR);
	localparam int RECIP_SHIFT = MS_W + RECIP_L;
	localparam int RECIP_W     = MS_W + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(TICK_DIVISOR) - 64'd1) / 64'(TICK_DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	// The reciprocal is applied in two parts on one narrower multiplier.
	localparam int PART_W = 17;
	localparam int PROD_W = MS_W + RECIP_W;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TICK = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

endpackage

/* rtl/ostb_div.sv */
// ----------------------------------------------------------------------------
// One-shot timer bank divider
// Turns milliseconds into ticks by multiplying with the reciprocal of the
// tick period, one partial product per cycle on a shared multiplier.
// ----------------------------------------------------------------------------
module ostb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ostb_pkg::MS_W-1:0]   dividend,
	output logic                        done,
	output logic [ostb_pkg::MS_W-1:0]   quotient
);

	logic [ostb_pkg::MS_W-1:0]                 x_q;
	logic [ostb_pkg::PROD_W-1:0]               acc_q;
	logic                                      phase_q;
	logic                                      run_q;
	logic                                      done_q;
	logic [ostb_pkg::PART_W-1:0]               mul_b;
	logic [ostb_pkg::MS_W+ostb_pkg::PART_W-1:0] part;
	logic [ostb_pkg::PROD_W-1:0]               part_ext;

	// Shared multiplier: the low part of the reciprocal first, then the high part.
	always_comb begin
		mul_b    = phase_q
			? ostb_pkg::PART_W'(ostb_pkg::RECIP[ostb_pkg::RECIP_W-1:ostb_pkg::PART_W])
			: ostb_pkg::RECIP[ostb_pkg::PART_W-1:0];
		part     = (ostb_pkg::MS_W+ostb_pkg::PART_W)'(x_q)
			* (ostb_pkg::MS_W+ostb_pkg::PART_W)'(mul_b);
		part_ext = phase_q ? (ostb_pkg::PROD_W'(part) << ostb_pkg::PART_W)
			: ostb_pkg::PROD_W'(part);
	end

	// Control: phase of the multiplication and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
			end else if (run_q) begin
				phase_q <= 1'b1;
				if (phase_q) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: capture the dividend, then accumulate the two partial products.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end else if (run_q) begin
			acc_q <= phase_q ? (acc_q + part_ext) : part_ext;
		end
	end

	assign done     = done_q;
	assign quotient = ostb_pkg::MS_W'(acc_q >> ostb_pkg::RECIP_SHIFT);

endmodule

/* rtl/one_shot_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// One-shot timer bank
// Eight one-shot down-counting timers advanced by a periodic 10 ms tick.
// ----------------------------------------------------------------------------
// Usage: present cmd, timer_index and time_ms with start high; the beat is
// taken at a rising edge where busy is low. For a set, or a tick while any
// timer is active, busy then stays high until the command has been carried
// out. Every command gives exactly one result beat: done is high for one cycle
// with expired_mask and active_mask, and the receiver must take it then, as it
// cannot stall the block.
// Per command:
//   tick with a nonzero active mask: a single decrement and compare unit
//     walks the counters one per cycle; set: the divider multiplies
//     milliseconds by the tick period's reciprocal in two partial products;
//   idle tick, clear-all and the unused code: finish at once.
// A new command is taken in the cycle its predecessor's result is shown.
// Reset clears all counts, armed flags and the active mask; the first
// command may be taken in the cycle after reset is released.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ostb_pkg::CMD_W-1:0]    cmd,
	input  logic [ostb_pkg::INDEX_W-1:0]  timer_index,
	input  logic [ostb_pkg::MS_W-1:0]     time_ms,
	output logic                          done,
	output logic [ostb_pkg::MASK_W-1:0]   expired_mask,
	output logic [ostb_pkg::MASK_W-1:0]   active_mask
);

	ostb_pkg::state_t                   state_q;
	ostb_pkg::cmd_t                     cmd_q;
	logic [ostb_pkg::INDEX_W-1:0]       index_q;
	logic [ostb_pkg::IDX_W-1:0]         walk_q;
	logic [ostb_pkg::COUNT_W-1:0]       rem_q [ostb_pkg::NUM_TIMERS];
	logic [ostb_pkg::NUM_TIMERS-1:0]    armed_q;
	logic [ostb_pkg::MASK_W-1:0]        active_q;
	logic [ostb_pkg::MASK_W-1:0]        expired_q;
	logic                               done_q;

	logic                               accept;
	ostb_pkg::cmd_t                     cmd_in;
	logic                               div_start;
	logic                               div_done;
	logic [ostb_pkg::MS_W-1:0]          div_quo;
	logic [ostb_pkg::COUNT_W-1:0]       rd_count;
	logic [ostb_pkg::COUNT_W-1:0]       dec_count;
	logic                               fire;
	logic                               last_walk;
	logic [ostb_pkg::COUNT_W-1:0]       set_count;
	logic                               set_ok;
	logic [ostb_pkg::MASK_W-1:0]        walk_bit;
	logic [ostb_pkg::MASK_W-1:0]        set_bit;

	assign accept    = start && (state_q == ostb_pkg::ST_IDLE);
	assign cmd_in    = ostb_pkg::cmd_t'(cmd);
	assign div_start = accept && (cmd_in == ostb_pkg::CMD_SET);

	// Reciprocal divider for the set command.
	ostb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (time_ms),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Shared decrement and compare unit for the counter under the walk index.
	always_comb begin
		rd_count  = rem_q[walk_q];
		dec_count = rd_count - ostb_pkg::COUNT_W'(rd_count != '0);
		fire      = (dec_count == '0) && armed_q[walk_q];
		last_walk = (walk_q == ostb_pkg::IDX_W'(ostb_pkg::NUM_TIMERS - 1));
		walk_bit  = ostb_pkg::MASK_W'(1) << walk_q;
	end

	// Saturate the quotient to the counter width and check the index.
	always_comb begin
		set_count = (|div_quo[ostb_pkg::MS_W-1:ostb_pkg::COUNT_W])
			? '1 : div_quo[ostb_pkg::COUNT_W-1:0];
		set_ok    = ({1'b0, index_q} < (ostb_pkg::INDEX_W+1)'(ostb_pkg::NUM_TIMERS));
		set_bit   = ostb_pkg::MASK_W'(1) << index_q;
	end

	// Sequencer and bank state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ostb_pkg::ST_IDLE;
			cmd_q     <= ostb_pkg::CMD_NONE;
			index_q   <= '0;
			walk_q    <= '0;
			armed_q   <= '0;
			active_q  <= '0;
			expired_q <= '0;
			done_q    <= 1'b0;
			for (int k = 0; k < ostb_pkg::NUM_TIMERS; k++) begin
				rem_q[k] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ostb_pkg::ST_IDLE: begin
					if (start) begin
						cmd_q     <= cmd_in;
						index_q   <= timer_index;
						walk_q    <= '0;
						expired_q <= '0;
						if (cmd_in == ostb_pkg::CMD_SET) begin
							state_q <= ostb_pkg::ST_DIV;
						end else if (cmd_in == ostb_pkg::CMD_TICK && active_q != '0) begin
							state_q <= ostb_pkg::ST_TICK;
						end else begin
							// Idle tick, clear-all and the unused code finish at once.
							done_q <= 1'b1;
							if (cmd_in == ostb_pkg::CMD_CLEAR) begin
								armed_q  <= '0;
								active_q <= '0;
								for (int k = 0; k < ostb_pkg::NUM_TIMERS; k++) begin
									rem_q[k] <= '0;
								end
							end
						end
					end
				end
				ostb_pkg::ST_TICK: begin
					rem_q[walk_q] <= dec_count;
					if (fire) begin
						armed_q[walk_q] <= 1'b0;
						active_q        <= active_q & ~walk_bit;
						expired_q       <= expired_q | walk_bit;
					end
					walk_q <= walk_q + 1'b1;
					if (last_walk) begin
						state_q <= ostb_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ostb_pkg::ST_DIV: begin
					if (div_done) begin
						if (set_ok) begin
							rem_q[index_q[ostb_pkg::IDX_W-1:0]]   <= set_count;
							armed_q[index_q[ostb_pkg::IDX_W-1:0]] <= (set_count != '0);
							active_q <= active_q | set_bit;
						end
						state_q <= ostb_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ostb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ostb_pkg::ST_IDLE);
	assign done         = done_q;
	assign expired_mask = expired_q;
	assign active_mask  = active_q;

	// A result beat is only shown once the sequencer is back at rest.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while the sequencer is busy");

	// Only a tick can report expired timers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && expired_mask != '0) |-> (cmd_q == ostb_pkg::CMD_TICK))
		else $error("expired timers reported for a command other than tick");

	// An expired timer has lost its active bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((expired_mask & active_mask) == '0))
		else $error("timer both expired and active");

	// An armed timer is always active.
	assert property (@(posedge clk) disable iff (!arst_n)
		((ostb_pkg::MASK_W'(armed_q) & ~active_q) == '0))
		else $error("armed timer without its active bit");

	// The divider completes only while a set command waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ostb_pkg::ST_DIV))
		else $error("divider completed outside a set command");

endmodule
